/* sv/assert_macros.svh */
// assertion macros shared by the vector normalizer rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define VN2_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("vn2 implication check failed");

`define VN2_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("vn2 next-cycle check failed");

`else

`define VN2_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`define VN2_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* sv/vn2_pkg.sv */
// shared constants and types for the 2d vector normalizer
// no dependencies
`default_nettype none

package vn2_pkg;

  localparam int FRAC_BITS = 14;                 // q2.14 output
  localparam int Q_BITS    = FRAC_BITS + 1;      // quotient magnitude bits, max 16384
  localparam int UNIT_BITS = 16;                 // width of one output component
  localparam int C_SHIFT   = 2 * FRAC_BITS + 2;  // c^2 scaled by 4 * 2^(2*frac)

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero;
  } vn2_flags_t;

endpackage

`default_nettype wire

/* sv/vn2_prep.sv */
// front end: component magnitudes, squares, sum of squares, initial residuals
// depends on vn2_pkg
`default_nettype none

module vn2_prep #(
  parameter int  COMP_BITS = 16,
  localparam int WD = 2 * COMP_BITS + vn2_pkg::C_SHIFT + 2,
  localparam int WT = 2 * COMP_BITS + vn2_pkg::Q_BITS + 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMP_BITS-1:0]      comp_x,
  input  logic [COMP_BITS-1:0]      comp_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output vn2_pkg::vn2_flags_t       flags_o,
  output logic [2*COMP_BITS-1:0]    s_o,
  output logic signed [WD-1:0]      dx_o,
  output logic signed [WD-1:0]      dy_o,
  output logic signed [WT-1:0]      tx_o,
  output logic signed [WT-1:0]      ty_o
);
  import vn2_pkg::*;

  localparam int SW = 2 * COMP_BITS;

  // stage 1: magnitudes
  logic                 v1_r;
  logic [COMP_BITS-1:0] magx1_r, magy1_r;
  vn2_flags_t           flags1_r;
  // stage 2: squares
  logic                 v2_r;
  logic [SW-1:0]        sqx2_r, sqy2_r;
  vn2_flags_t           flags2_r;
  // stage 3: sum and residual seeds
  logic                 v3_r;
  logic [SW-1:0]        s3_r;
  logic signed [WD-1:0] dx3_r, dy3_r;
  logic signed [WT-1:0] tx3_r, ty3_r;
  vn2_flags_t           flags3_r;

  logic          rdy1, rdy2, rdy3;
  logic [COMP_BITS-1:0] magx_nxt, magy_nxt;
  vn2_flags_t    flags_nxt;
  logic [SW-1:0] s_nxt;
  logic signed [WD-1:0] s_wd, dx_nxt, dy_nxt;
  logic signed [WT-1:0] t_nxt;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // most negative input maps to 2^(n-1), which still fits unsigned
  always_comb begin
    flags_nxt.neg_x = comp_x[COMP_BITS-1];
    flags_nxt.neg_y = comp_y[COMP_BITS-1];
    flags_nxt.zero  = (comp_x == '0) && (comp_y == '0);
    magx_nxt = comp_x[COMP_BITS-1] ? (~comp_x + 1'b1) : comp_x;
    magy_nxt = comp_y[COMP_BITS-1] ? (~comp_y + 1'b1) : comp_y;
  end

  // residual seed d0 = c^2 * 2^30 - s, running product t0 = -s (trial odd value -1)
  always_comb begin
    s_nxt  = sqx2_r + sqy2_r;
    s_wd   = $signed({{(WD-SW){1'b0}}, s_nxt});
    dx_nxt = $signed({{(WD-SW-C_SHIFT){1'b0}}, sqx2_r, {C_SHIFT{1'b0}}}) - s_wd;
    dy_nxt = $signed({{(WD-SW-C_SHIFT){1'b0}}, sqy2_r, {C_SHIFT{1'b0}}}) - s_wd;
    t_nxt  = -$signed({{(WT-SW){1'b0}}, s_nxt});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      magx1_r  <= magx_nxt;
      magy1_r  <= magy_nxt;
      flags1_r <= flags_nxt;
    end
    if (rdy2 && v1_r) begin
      sqx2_r   <= SW'(magx1_r) * SW'(magx1_r);
      sqy2_r   <= SW'(magy1_r) * SW'(magy1_r);
      flags2_r <= flags1_r;
    end
    if (rdy3 && v2_r) begin
      s3_r     <= s_nxt;
      dx3_r    <= dx_nxt;
      dy3_r    <= dy_nxt;
      tx3_r    <= t_nxt;
      ty3_r    <= t_nxt;
      flags3_r <= flags2_r;
    end
  end

  assign out_valid = v3_r;
  assign flags_o   = flags3_r;
  assign s_o       = s3_r;
  assign dx_o      = dx3_r;
  assign dy_o      = dy3_r;
  assign tx_o      = tx3_r;
  assign ty_o      = ty3_r;

endmodule

`default_nettype wire

/* sv/vn2_cell.sv */
// one quotient bit for both lanes: trial subtract of the squared-odd residual
// depends on vn2_pkg
`default_nettype none

module vn2_cell #(
  parameter int  COMP_BITS = 16,
  parameter int  J = 0,
  localparam int WD = 2 * COMP_BITS + vn2_pkg::C_SHIFT + 2,
  localparam int WT = 2 * COMP_BITS + vn2_pkg::Q_BITS + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  vn2_pkg::vn2_flags_t        flags_i,
  input  logic [2*COMP_BITS-1:0]     s_i,
  input  logic signed [WD-1:0]       dx_i,
  input  logic signed [WD-1:0]       dy_i,
  input  logic signed [WT-1:0]       tx_i,
  input  logic signed [WT-1:0]       ty_i,
  input  logic [vn2_pkg::Q_BITS-1:0] qx_i,
  input  logic [vn2_pkg::Q_BITS-1:0] qy_i,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vn2_pkg::vn2_flags_t        flags_o,
  output logic [2*COMP_BITS-1:0]     s_o,
  output logic signed [WD-1:0]       dx_o,
  output logic signed [WD-1:0]       dy_o,
  output logic signed [WT-1:0]       tx_o,
  output logic signed [WT-1:0]       ty_o,
  output logic [vn2_pkg::Q_BITS-1:0] qx_o,
  output logic [vn2_pkg::Q_BITS-1:0] qy_o
);
  import vn2_pkg::*;

  localparam int SW = 2 * COMP_BITS;

  logic                 v_r;
  vn2_flags_t           flags_r;
  logic [SW-1:0]        s_r;
  logic signed [WD-1:0] dx_r, dy_r;
  logic signed [WT-1:0] tx_r, ty_r;
  logic [Q_BITS-1:0]    qx_r, qy_r;

  logic                 rdy;
  logic signed [WD-1:0] b_term, dxt, dyt, dx_nxt, dy_nxt;
  logic signed [WT-1:0] t_step, tx_nxt, ty_nxt;
  logic                 take_x, take_y;
  logic [Q_BITS-1:0]    qx_nxt, qy_nxt;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  // raising the trial odd value t by 2^(j+1) grows t^2*s by 2^(j+2)*t*s + 2^(2j+2)*s
  always_comb begin
    b_term = $signed({{(WD-SW){1'b0}}, s_i}) <<< (2 * J + 2);
    t_step = $signed({{(WT-SW){1'b0}}, s_i}) <<< (J + 1);
    dxt    = dx_i - ($signed({{(WD-WT){tx_i[WT-1]}}, tx_i}) <<< (J + 2)) - b_term;
    dyt    = dy_i - ($signed({{(WD-WT){ty_i[WT-1]}}, ty_i}) <<< (J + 2)) - b_term;
    take_x = !dxt[WD-1];
    take_y = !dyt[WD-1];
    dx_nxt = take_x ? dxt : dx_i;
    dy_nxt = take_y ? dyt : dy_i;
    tx_nxt = take_x ? (tx_i + t_step) : tx_i;
    ty_nxt = take_y ? (ty_i + t_step) : ty_i;
    qx_nxt = qx_i;
    qy_nxt = qy_i;
    qx_nxt[J] = take_x;
    qy_nxt[J] = take_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      flags_r <= flags_i;
      s_r     <= s_i;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      tx_r    <= tx_nxt;
      ty_r    <= ty_nxt;
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
    end
  end

  assign out_valid = v_r;
  assign flags_o   = flags_r;
  assign s_o       = s_r;
  assign dx_o      = dx_r;
  assign dy_o      = dy_r;
  assign tx_o      = tx_r;
  assign ty_o      = ty_r;
  assign qx_o      = qx_r;
  assign qy_o      = qy_r;

endmodule

`default_nettype wire

/* sv/vn2_out.sv */
// output register: sign restore, zero-vector override, result beat
// depends on vn2_pkg
`default_nettype none

module vn2_out (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  vn2_pkg::vn2_flags_t            flags_i,
  input  logic [vn2_pkg::Q_BITS-1:0]     qx_i,
  input  logic [vn2_pkg::Q_BITS-1:0]     qy_i,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [vn2_pkg::UNIT_BITS-1:0]  unit_x,
  output logic [vn2_pkg::UNIT_BITS-1:0]  unit_y,
  output logic                           was_zero
);
  import vn2_pkg::*;

  logic                 v_r;
  logic [UNIT_BITS-1:0] ux_r, uy_r;
  logic                 zero_r;
  logic                 rdy;
  logic [UNIT_BITS-1:0] ux_nxt, uy_nxt, mx, my;

  assign rdy      = !v_r || out_ready;
  assign in_ready = rdy;

  always_comb begin
    mx = {{(UNIT_BITS-Q_BITS){1'b0}}, qx_i};
    my = {{(UNIT_BITS-Q_BITS){1'b0}}, qy_i};
    ux_nxt = flags_i.neg_x ? (~mx + 1'b1) : mx;
    uy_nxt = flags_i.neg_y ? (~my + 1'b1) : my;
    if (flags_i.zero) begin
      ux_nxt = '0;
      uy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (rdy) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      ux_r   <= ux_nxt;
      uy_r   <= uy_nxt;
      zero_r <= flags_i.zero;
    end
  end

  assign out_valid = v_r;
  assign unit_x    = ux_r;
  assign unit_y    = uy_r;
  assign was_zero  = zero_r;

endmodule

`default_nettype wire

/* sv/vector_normalize_2d.sv */
// top level of the 2d vector normalizer: (x, y) -> rounded q2.14 unit vector
// depends on vn2_pkg, vn2_prep, vn2_cell, vn2_out and assert_macros.svh
//
//   port group   dir   tdata fields (lsb first)        tuser
//   in_*         in    comp_x, comp_y (+ zero pad)     -
//   out_*        out   unit_x, unit_y                  was_zero
//
// one beat per clock sustained while out_tready stays high; beats pass the front
// end, a row of 15 quotient cells (one bit of both lanes each) and the output
// register; every stage has its own valid bit, so a stall only backs up full
// stages and a waiting result never blocks beats entering empty stages behind it
// reset (rst_n low, synchronous) clears the valid bits only
`default_nettype none
`include "assert_macros.svh"

module vector_normalize_2d #(
  parameter int  COMP_BITS = 16,
  localparam int IN_W = ((2 * COMP_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,   // comp_x, comp_y, zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [2*vn2_pkg::UNIT_BITS-1:0]   out_tdata,  // unit_x, unit_y
  output logic                              out_tuser   // was_zero
);
  import vn2_pkg::*;

  localparam int WD = 2 * COMP_BITS + C_SHIFT + 2;  // residual width
  localparam int WT = 2 * COMP_BITS + Q_BITS + 1;   // running t*s width
  localparam int SW = 2 * COMP_BITS;                // sum of squares width

  // chain taps: index 0 is the front end output, index Q_BITS the last cell
  logic                 v_c     [Q_BITS+1];
  logic                 rdy_c   [Q_BITS+1];
  vn2_flags_t           flags_c [Q_BITS+1];
  logic [SW-1:0]        s_c     [Q_BITS+1];
  logic signed [WD-1:0] dx_c    [Q_BITS+1];
  logic signed [WD-1:0] dy_c    [Q_BITS+1];
  logic signed [WT-1:0] tx_c    [Q_BITS+1];
  logic signed [WT-1:0] ty_c    [Q_BITS+1];
  logic [Q_BITS-1:0]    qx_c    [Q_BITS+1];
  logic [Q_BITS-1:0]    qy_c    [Q_BITS+1];

  logic [UNIT_BITS-1:0] unit_x, unit_y;

  // front end: magnitude, squares, sum and residual seed over three stages
  vn2_prep #(.COMP_BITS(COMP_BITS)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .comp_x    (in_tdata[COMP_BITS-1:0]),
    .comp_y    (in_tdata[2*COMP_BITS-1:COMP_BITS]),
    .out_valid (v_c[0]),
    .out_ready (rdy_c[0]),
    .flags_o   (flags_c[0]),
    .s_o       (s_c[0]),
    .dx_o      (dx_c[0]),
    .dy_o      (dy_c[0]),
    .tx_o      (tx_c[0]),
    .ty_o      (ty_c[0])
  );

  // quotient starts empty; cells fill it from the msb down
  assign qx_c[0] = '0;
  assign qy_c[0] = '0;

  // row of quotient cells, msb first; cell g decides bit Q_BITS-1-g
  for (genvar g = 0; g < Q_BITS; g++) begin : g_cell
    vn2_cell #(.COMP_BITS(COMP_BITS), .J(Q_BITS - 1 - g)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_c[g]),
      .in_ready  (rdy_c[g]),
      .flags_i   (flags_c[g]),
      .s_i       (s_c[g]),
      .dx_i      (dx_c[g]),
      .dy_i      (dy_c[g]),
      .tx_i      (tx_c[g]),
      .ty_i      (ty_c[g]),
      .qx_i      (qx_c[g]),
      .qy_i      (qy_c[g]),
      .out_valid (v_c[g+1]),
      .out_ready (rdy_c[g+1]),
      .flags_o   (flags_c[g+1]),
      .s_o       (s_c[g+1]),
      .dx_o      (dx_c[g+1]),
      .dy_o      (dy_c[g+1]),
      .tx_o      (tx_c[g+1]),
      .ty_o      (ty_c[g+1]),
      .qx_o      (qx_c[g+1]),
      .qy_o      (qy_c[g+1])
    );
  end

  // result register with sign restore and zero-vector override
  vn2_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_c[Q_BITS]),
    .in_ready  (rdy_c[Q_BITS]),
    .flags_i   (flags_c[Q_BITS]),
    .qx_i      (qx_c[Q_BITS]),
    .qy_i      (qy_c[Q_BITS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .unit_x    (unit_x),
    .unit_y    (unit_y),
    .was_zero  (out_tuser)
  );

  assign out_tdata = {unit_y, unit_x};

  // a zero vector always comes out as (0, 0)
  `VN2_ASSERT_IMP(a_zero_out, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0)

  // unit components never leave -1.0 .. +1.0
  `VN2_ASSERT_IMP(a_range, clk, rst_n, out_tvalid,
    ($signed(unit_x) <= 16'sd16384) && ($signed(unit_x) >= -16'sd16384) &&
    ($signed(unit_y) <= 16'sd16384) && ($signed(unit_y) >= -16'sd16384))

  // input backs up only when every stage is full and the result is held
  `VN2_ASSERT_IMP(a_backpressure, clk, rst_n, !in_tready, out_tvalid && !out_tready)

  // a result beat that is not taken stays put with the same contents
  `VN2_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable({out_tuser, out_tdata}))

endmodule

`default_nettype wire

/* sim/tb_vector_normalize_2d.sv */
// self-checking testbench for vector_normalize_2d: directed and random vectors
// with random source gaps, sink stalls and a long sink hold-off
// depends on vn2_pkg and the vector_normalize_2d rtl
`default_nettype none

module tb_vector_normalize_2d;
  import vn2_pkg::*;

  localparam int COMP_BITS   = 16;
  localparam int IN_W        = ((2 * COMP_BITS + 7) / 8) * 8;
  localparam int PIPE_CYCLES = 19;       // pipeline depth allowance for the final idle wait
  localparam int CYCLE_LIMIT = 250000;   // far above the slowest legal run
  localparam int DRAIN_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;
  localparam int RAND_ITEMS  = 300;      // per idling phase

  // one expected output beat
  typedef struct {
    logic [UNIT_BITS-1:0] ux;
    logic [UNIT_BITS-1:0] uy;
    logic                 zero;
  } unit_beat_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata = '0;   // comp_x, comp_y
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [2*UNIT_BITS-1:0] out_tdata;       // unit_x, unit_y
  logic                   out_tuser;       // was_zero

  unit_beat_t units_due[$];   // predicted unit vectors, oldest first
  int         in_idle_pct   = 0;
  int         out_stall_pct = 0;
  int         hold_len      = 0;   // requested sink hold-off in cycles
  logic       rx_hold       = 1'b0;
  int         err_cnt       = 0;
  int         mism_cnt      = 0;
  int         cycle_cnt     = 0;

  vector_normalize_2d #(.COMP_BITS(COMP_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // rounded |c| * 2^frac / m, found as the largest k with k - 1/2 <= |c| * 2^frac / m,
  // i.e. (2k-1)^2 * s <= c^2 * 2^(2*frac+2); exact halves land on the upper k
  function automatic logic [UNIT_BITS-1:0] unit_comp(logic signed [COMP_BITS-1:0] c,
                                                      longint unsigned s);
    longint unsigned mag, lim, lo, hi, mid, odd;
    mag = (c < 0) ? -longint'(c) : longint'(c);
    lim = (mag * mag) << C_SHIFT;
    lo  = 0;
    hi  = 1 << FRAC_BITS;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      odd = 2 * mid - 1;
      if (odd * odd * s <= lim)
        lo = mid;
      else
        hi = mid - 1;
    end
    // sign put back after rounding, so results mirror about zero
    return (c < 0) ? UNIT_BITS'(-lo) : UNIT_BITS'(lo);
  endfunction

  function automatic unit_beat_t normalize_vec(logic signed [COMP_BITS-1:0] x,
                                               logic signed [COMP_BITS-1:0] y);
    unit_beat_t      r;
    longint          sx, sy;
    longint unsigned s;
    sx = x;
    sy = y;
    s  = sx * sx + sy * sy;   // most negative component squared exactly
    if (s == 0) begin
      r.ux   = '0;
      r.uy   = '0;
      r.zero = 1'b1;
    end else begin
      r.ux   = unit_comp(x, s);
      r.uy   = unit_comp(y, s);
      r.zero = 1'b0;
    end
    return r;
  endfunction

  // random vector, packed {y, x}; mixes full range, tiny, axis and near-extreme cases
  function automatic logic [2*COMP_BITS-1:0] random_vector();
    logic [COMP_BITS-1:0] x, y;
    x = $urandom;
    y = $urandom;
    case ($urandom_range(9))
      5, 6: begin
        x = COMP_BITS'($signed($urandom_range(63)) - 32);
        y = COMP_BITS'($signed($urandom_range(63)) - 32);
      end
      7: begin
        // one component on an axis value
        case ($urandom_range(4))
          0: x = 16'h8000;
          1: x = 16'h7fff;
          2: x = 16'h0000;
          3: x = 16'h0001;
          default: x = 16'hffff;
        endcase
        if ($urandom_range(1)) {x, y} = {y, x};
      end
      8: begin
        // both components close to full scale
        x = 16'h7fff - COMP_BITS'($urandom_range(255));
        y = 16'h7fff - COMP_BITS'($urandom_range(255));
        if ($urandom_range(1)) x = ~x;
        if ($urandom_range(1)) y = ~y;
      end
      9: begin
        x = COMP_BITS'($signed($urandom_range(2)) - 1);
        y = COMP_BITS'($signed($urandom_range(2)) - 1);
      end
      default: ;
    endcase
    return {y, x};
  endfunction

  // offer one vector, with a random idle gap first; record the prediction on the beat
  task automatic send_vector(logic signed [COMP_BITS-1:0] x,
                             logic signed [COMP_BITS-1:0] y);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    units_due.insert(units_due.size(), normalize_vec(x, y));
  endtask

  task automatic send_random(int n);
    logic [2*COMP_BITS-1:0] v;
    repeat (n) begin
      v = random_vector();
      send_vector(v[COMP_BITS-1:0], v[2*COMP_BITS-1:COMP_BITS]);
    end
  endtask

  // source parks until every predicted beat has come out or DRAIN_LIMIT runs out
  task automatic wait_drained();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (units_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic test_zero_vector();
    send_vector(16'sd0, 16'sd0);
    send_vector(16'sd1, 16'sd0);
    send_vector(16'sd0, 16'sd0);   // zero right after a nonzero vector
    send_vector(-16'sd1, -16'sd1);
    send_vector(16'sd0, 16'sd0);
  endtask

  task automatic test_axis_extremes();
    send_vector(16'sd32767, 16'sd0);
    send_vector(-16'sd32768, 16'sd0);
    send_vector(16'sd0, -16'sd32768);
    send_vector(16'sd0, 16'sd32767);
    send_vector(-16'sd32768, -16'sd32768);
    send_vector(16'sd32767, 16'sd32767);
    send_vector(16'sd32767, -16'sd32768);
    send_vector(-16'sd32768, 16'sd1);
    send_vector(16'sd1, 16'sd32767);
    send_vector(16'sd0, -16'sd1);
  endtask

  task automatic test_rounding();
    // quotients with fractions on both sides of one half
    send_vector(16'sd3, 16'sd4);
    send_vector(-16'sd3, -16'sd4);
    send_vector(16'sd1, 16'sd2);
    send_vector(16'sd5, -16'sd12);
    send_vector(-16'sd1, 16'sd1);
    send_vector(16'sd100, -16'sd100);
    send_vector(16'sd1, 16'sd3);
    send_vector(-16'sd7, 16'sd24);
  endtask

  task automatic test_random_phases();
    // no idling, source gaps, sink stalls, then both
    in_idle_pct = 0;  out_stall_pct = 0;  send_random(RAND_ITEMS);
    in_idle_pct = 56; out_stall_pct = 0;  send_random(RAND_ITEMS);
    in_idle_pct = 0;  out_stall_pct = 56; send_random(RAND_ITEMS);
    in_idle_pct = 32; out_stall_pct = 32; send_random(RAND_ITEMS);
  endtask

  task automatic test_backpressure_fill();
    // long sink hold-off while the source keeps offering: pipe fills and stalls input
    in_idle_pct   = 0;
    out_stall_pct = 0;
    hold_len      = 300;
    send_random(60);
    wait_drained();
  endtask

  task automatic test_drain_pause();
    in_idle_pct   = 32;
    out_stall_pct = 32;
    send_random(20);
    wait_drained();
    send_random(20);
  endtask

  // sink: check each output beat against the oldest prediction, then pick next tready
  always @(posedge clk) begin : sink
    unit_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (units_due.size() == 0) begin
        err_cnt++;
        mism_cnt++;
        if (mism_cnt <= MAX_REPORTS)
          $display("unexpected beat: unit_x %0d unit_y %0d was_zero %0b",
                   $signed(out_tdata[UNIT_BITS-1:0]),
                   $signed(out_tdata[2*UNIT_BITS-1:UNIT_BITS]), out_tuser);
      end else begin
        want = units_due.pop_front();
        if (out_tdata[UNIT_BITS-1:0] !== want.ux ||
            out_tdata[2*UNIT_BITS-1:UNIT_BITS] !== want.uy ||
            out_tuser !== want.zero) begin
          err_cnt++;
          mism_cnt++;
          if (mism_cnt <= MAX_REPORTS)
            $display("mismatch: exp (%0d, %0d, %0b) got (%0d, %0d, %0b)",
                     $signed(want.ux), $signed(want.uy), want.zero,
                     $signed(out_tdata[UNIT_BITS-1:0]),
                     $signed(out_tdata[2*UNIT_BITS-1:UNIT_BITS]), out_tuser);
        end
      end
    end
    out_tready <= !rx_hold && ($urandom_range(99) >= out_stall_pct);
  end

  // sink hold-off, counted here so the source task stays free to push
  always begin
    wait (hold_len > 0);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (hold_len) @(posedge clk);
    rx_hold <= 1'b0;
    hold_len = 0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_vector();
    test_axis_extremes();
    test_rounding();
    test_random_phases();
    test_backpressure_fill();
    test_drain_pause();

    // let the pipe empty, then stay idle to catch stray beats
    wait_drained();
    repeat (PIPE_CYCLES + 5) @(posedge clk);
    err_cnt += units_due.size();

    if (err_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
